>>> design/dns_query_parser_defines.svh
// Assertion macros used by the checker file of the DNS query parser.
// Each macro checks a property on the rising edge of clk, disabled while rst_n is low.
`ifndef DNS_QUERY_PARSER_DEFINES_SVH
`define DNS_QUERY_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DQP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/dqp_pkg.sv
package dqp_pkg;

  localparam int unsigned HDR_WORDS = 6;
  localparam logic [15:0] HDR_BYTES = 16'd12;
  localparam logic [16:0] TC_BYTES  = 17'd4;
  localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_COUNT = 2'd2;
  localparam logic [1:0] STATUS_TRUNC = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_TYPE_CLASS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] question_end;
    logic [15:0] query_id;
    logic [15:0] header_flags;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [15:0] query_type;
    logic [15:0] query_class;
  } out_item_t;

  // Replaces the high or low byte of a big-endian 16-bit word.
  function automatic logic [15:0] put_byte(input logic [15:0] word, input logic high,
                                           input logic [7:0] b);
    logic [15:0] res;
    if (high) begin
      res = {b, word[7:0]};
    end else begin
      res = {word[15:8], b};
    end
    return res;
  endfunction

endpackage

>>> design/dqp_in_stage.sv
module dqp_in_stage import dqp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_stall,
  input  logic     blocked,
  output logic     step,
  output in_item_t item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     take;
  logic     hold;

  // The held byte moves on unless it is a last byte facing a full, stalled result register.
  assign hold     = valid_r && blocked && item_r.last_byte;
  assign step     = valid_r && !hold;
  assign in_stall = hold;
  assign take     = in_valid && !in_stall;
  assign item     = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

endmodule

>>> design/dqp_parser.sv
module dqp_parser import dqp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  output logic      emit,
  output out_item_t result
);

  logic [15:0] offset_r, offset_nxt;
  logic [15:0] hdr_r [HDR_WORDS];
  logic [15:0] hdr_nxt [HDR_WORDS];
  logic [16:0] nlo_r, nlo_nxt;
  phase_t      phase_r, phase_nxt;
  logic [16:0] ne_r, ne_nxt;
  logic [15:0] tc_r [2];
  logic [15:0] tc_nxt [2];

  logic [16:0] off17;
  logic [16:0] k;
  logic [16:0] len;
  logic [16:0] qsum;
  logic [1:0]  status;
  logic [7:0]  b;

  assign b    = item.data_byte;
  assign emit = step && item.last_byte;

  always_comb begin
    off17      = {1'b0, offset_r};
    k          = off17 - ne_r;
    hdr_nxt    = hdr_r;
    tc_nxt     = tc_r;
    nlo_nxt    = nlo_r;
    ne_nxt     = ne_r;
    phase_nxt  = phase_r;
    case (phase_r)
      PH_HEADER: begin
        if (offset_r < HDR_BYTES) begin
          for (int i = 0; i < HDR_WORDS; i++) begin
            if (offset_r[3:1] == 3'(i)) begin
              hdr_nxt[i] = put_byte(hdr_r[i], !offset_r[0], b);
            end
          end
        end
        if (offset_r >= HDR_BYTES - 16'd1) begin
          phase_nxt = PH_NAME;
        end
      end
      PH_NAME: begin
        if (off17 == nlo_r) begin
          if (b == 8'd0) begin
            ne_nxt    = off17 + 17'd1;
            phase_nxt = PH_TYPE_CLASS;
          end else begin
            nlo_nxt = nlo_r + {9'd0, b} + 17'd1;
          end
        end
      end
      PH_TYPE_CLASS: begin
        if (off17 >= ne_r && k < TC_BYTES) begin
          tc_nxt[k[1]] = put_byte(tc_r[k[1]], !k[0], b);
          if (k == TC_BYTES - 17'd1) begin
            phase_nxt = PH_DONE;
          end
        end
      end
      default: begin
      end
    endcase

    offset_nxt = (offset_r == OFFSET_MAX) ? offset_r : offset_r + 16'd1;

    len  = off17 + 17'd1;
    qsum = ne_nxt + TC_BYTES;
    if (len < {1'b0, HDR_BYTES}) begin
      status = STATUS_SHORT;
    end else if (hdr_nxt[2] != 16'd1) begin
      status = STATUS_COUNT;
    end else if (phase_nxt == PH_HEADER || phase_nxt == PH_NAME) begin
      status = STATUS_TRUNC;
    end else if (qsum > len) begin
      status = STATUS_TRUNC;
    end else begin
      status = STATUS_OK;
    end

    result.status           = status;
    result.question_end     = (status != STATUS_OK) ? 16'd0 :
                              (qsum[16] ? OFFSET_MAX : qsum[15:0]);
    result.query_id         = (status == STATUS_SHORT) ? 16'd0 : hdr_nxt[0];
    result.header_flags     = (status == STATUS_SHORT) ? 16'd0 : hdr_nxt[1];
    result.question_count   = (status == STATUS_SHORT) ? 16'd0 : hdr_nxt[2];
    result.answer_count     = (status == STATUS_SHORT) ? 16'd0 : hdr_nxt[3];
    result.authority_count  = (status == STATUS_SHORT) ? 16'd0 : hdr_nxt[4];
    result.additional_count = (status == STATUS_SHORT) ? 16'd0 : hdr_nxt[5];
    result.query_type       = (status == STATUS_OK) ? tc_nxt[0] : 16'd0;
    result.query_class      = (status == STATUS_OK) ? tc_nxt[1] : 16'd0;
  end

  // The last byte of a packet returns every register to its reset value.
  always_ff @(posedge clk) begin
    if (!rst_n || emit) begin
      offset_r <= 16'd0;
      for (int i = 0; i < HDR_WORDS; i++) begin
        hdr_r[i] <= 16'd0;
      end
      nlo_r    <= {1'b0, HDR_BYTES};
      phase_r  <= PH_HEADER;
      ne_r     <= 17'd0;
      tc_r[0]  <= 16'd0;
      tc_r[1]  <= 16'd0;
    end else if (step) begin
      offset_r <= offset_nxt;
      hdr_r    <= hdr_nxt;
      nlo_r    <= nlo_nxt;
      phase_r  <= phase_nxt;
      ne_r     <= ne_nxt;
      tc_r     <= tc_nxt;
    end
  end

endmodule

>>> design/dqp_out_stage.sv
module dqp_out_stage import dqp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      emit,
  input  out_item_t result,
  output logic      blocked,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  assign blocked   = valid_r && out_stall;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (emit) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      item_r <= result;
    end
  end

endmodule

>>> design/dns_query_parser.sv
// DNS query parser. Bytes of one DNS packet enter in order, one per transfer on the in_
// channel, with last_byte set on the final byte. The block captures the six header words,
// walks the QNAME labels (each length byte taken as an unsigned count, compression pointers
// not recognized), captures QTYPE and QCLASS, and on the final byte sends one result
// transfer on the out_ channel with a status and the header and question fields. Status
// 0 is ok, 1 is a packet shorter than the 12-byte header, 2 is a question count other than
// one, and 3 is a question cut short; the checks are applied in that order. Header words
// read as zero on status 1, and question_end, query_type and query_class read as zero on
// any status other than ok. The byte offset saturates at 65535, so later bytes of a very
// long packet all count as lying at that offset. The block accepts one byte every cycle
// while in_stall is low. A last byte is held in the input register and parsed from there,
// and its parse loads the result register and raises out_valid. The input side stalls
// only when a last byte waits in the input register while the previous result is still
// held and stalled.
module dns_query_parser import dqp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_item,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      blocked;
  logic      step;
  in_item_t  item;
  logic      emit;
  out_item_t result;

  // Input register: holds one accepted byte for the parsing logic.
  dqp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .blocked  (blocked),
    .step     (step),
    .item     (item)
  );

  // Parsing state and the per-byte update, including the status decision on the last byte.
  dqp_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .emit   (emit),
    .result (result)
  );

  // Result register: a finished result waits here while new bytes keep arriving.
  dqp_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .result    (result),
    .blocked   (blocked),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> design/dqp_checker.sv
`include "dns_query_parser_defines.svh"

module dqp_checker import dqp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  logic short_res;
  logic short_zero;
  logic fail_res;
  logic fail_zero;

  assign short_res  = out_valid && out_item.status == STATUS_SHORT;
  assign short_zero = out_item.query_id == 16'd0 && out_item.header_flags == 16'd0 &&
                      out_item.question_count == 16'd0 && out_item.answer_count == 16'd0 &&
                      out_item.authority_count == 16'd0 &&
                      out_item.additional_count == 16'd0;
  assign fail_res   = out_valid && out_item.status != STATUS_OK;
  assign fail_zero  = out_item.question_end == 16'd0 && out_item.query_type == 16'd0 &&
                      out_item.query_class == 16'd0;

  `DQP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `DQP_ASSERT_SAME(a_in_stall_cause, in_stall, out_valid && out_stall, "stall without cause")
  `DQP_ASSERT_SAME(a_short_zero, short_res, short_zero, "short packet shows header words")
  `DQP_ASSERT_SAME(a_fail_zero, fail_res, fail_zero, "failed parse shows question fields")

endmodule

bind dns_query_parser dqp_checker u_dqp_checker (.*);
